### rtl/upr_pkg.sv
`timescale 1ns / 1ps

package upr_pkg;

  localparam int WIDTH_W = 17;
  localparam int DIST_W  = 22;
  localparam int TRIG_W  = 8;
  localparam int GAP_W   = 24;
  localparam int DBNC_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // echo ticks to thousandths of a cm: 340 m/s, halved for the round trip
  localparam int DIST_FACTOR = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LEN   = 3'd4;

  localparam logic [TRIG_W-1:0]  RST_TRIGGER_TICKS  = 8'd10;
  localparam logic [WIDTH_W-1:0] RST_TIMEOUT_TICKS  = 17'd100000;
  localparam logic [GAP_W-1:0]   RST_GAP_TICKS      = 24'd1000000;
  localparam logic [DIST_W-1:0]  RST_PRESENCE_LIMIT = 22'd160000;
  localparam logic [DBNC_W-1:0]  RST_DEBOUNCE_LEN   = 4'd6;

  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_WAIT    = 2'd1,
    PH_HIGH    = 2'd2,
    PH_GAP     = 2'd3
  } phase_t;

  typedef struct packed {
    logic [TRIG_W-1:0]  trigger_ticks;
    logic [WIDTH_W-1:0] timeout_ticks;
    logic [GAP_W-1:0]   gap_ticks;
    logic [DIST_W-1:0]  presence_limit;
    logic [DBNC_W-1:0]  debounce_len;
  } cfg_t;

  typedef struct packed {
    logic               trig;
    logic               done;
    logic [WIDTH_W-1:0] width;
  } seq_res_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_mcm;
    logic              raw;
    logic              presence;
  } dbnc_res_t;

endpackage

### rtl/ultrasonic_presence_ranger_unit.sv
`timescale 1ns / 1ps
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+-------------------------------------
// in_      | input     | in_valid / in_ready      | echo_level
// out_     | output    | out_valid / out_ready    | trigger_level .. presence, one per tick
// cfg_     | input     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One item a cycle while the output is not stalled; out_valid rises once the item
// has passed the input register, then the result register, with the sequencer and debouncer between.
// Reset loads the register defaults and starts in the trigger phase.
// A stalled output holds the result register; one further item waits in the
// input register, after which in_ready drops. cfg_ready is always high.

module ultrasonic_presence_ranger_unit #(
  parameter int GAP_TIMER_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_echo_level,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_trigger_level,
  output logic                               out_sample_valid,
  output logic [upr_pkg::WIDTH_W-1:0]        out_echo_width,
  output logic [upr_pkg::DIST_W-1:0]         out_distance_mcm,
  output logic                               out_raw_present,
  output logic                               out_presence,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [upr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [upr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  upr_pkg::cfg_t      cfg_r;
  upr_pkg::seq_res_t  seq_res;
  upr_pkg::dbnc_res_t dbnc_res;

  logic s1_v_r;
  logic s1_echo_r;
  logic out_v_r;
  logic adv;
  logic step_en;

  logic                          trig_r;
  logic                          done_r;
  logic [upr_pkg::WIDTH_W-1:0]   width_r;
  logic [upr_pkg::DIST_W-1:0]    dist_r;
  logic                          raw_r;
  logic                          pres_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_ticks  <= upr_pkg::RST_TRIGGER_TICKS;
      cfg_r.timeout_ticks  <= upr_pkg::RST_TIMEOUT_TICKS;
      cfg_r.gap_ticks      <= upr_pkg::RST_GAP_TICKS;
      cfg_r.presence_limit <= upr_pkg::RST_PRESENCE_LIMIT;
      cfg_r.debounce_len   <= upr_pkg::RST_DEBOUNCE_LEN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        upr_pkg::CFG_TRIGGER_TICKS:  cfg_r.trigger_ticks  <= cfg_data[upr_pkg::TRIG_W-1:0];
        upr_pkg::CFG_TIMEOUT_TICKS:  cfg_r.timeout_ticks  <= cfg_data[upr_pkg::WIDTH_W-1:0];
        upr_pkg::CFG_GAP_TICKS:      cfg_r.gap_ticks      <= cfg_data[upr_pkg::GAP_W-1:0];
        upr_pkg::CFG_PRESENCE_LIMIT: cfg_r.presence_limit <= cfg_data[upr_pkg::DIST_W-1:0];
        upr_pkg::CFG_DEBOUNCE_LEN:   cfg_r.debounce_len   <= cfg_data[upr_pkg::DBNC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // advance when the result register is free or being emptied
  assign adv      = !out_v_r || out_ready;
  assign step_en  = s1_v_r && adv;
  assign in_ready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_echo_r <= in_echo_level;
    end
  end

  upr_seq #(
    .GAP_TIMER_BITS (GAP_TIMER_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .echo    (s1_echo_r),
    .cfg     (cfg_r),
    .res     (seq_res)
  );

  upr_dbnc u_dbnc (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .seq     (seq_res),
    .cfg     (cfg_r),
    .res     (dbnc_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      trig_r  <= seq_res.trig;
      done_r  <= seq_res.done;
      width_r <= seq_res.width;
      dist_r  <= dbnc_res.dist_mcm;
      raw_r   <= dbnc_res.raw;
      pres_r  <= dbnc_res.presence;
    end
  end

  assign out_valid         = out_v_r;
  assign out_trigger_level = trig_r;
  assign out_sample_valid  = done_r;
  assign out_echo_width    = width_r;
  assign out_distance_mcm  = dist_r;
  assign out_raw_present   = raw_r;
  assign out_presence      = pres_r;

`ifndef SYNTHESIS
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !done_r) |-> (width_r == '0 && dist_r == '0 && !raw_r))
    else $error("fields set on a tick without a sample");

  a_no_trig_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(trig_r && done_r))
    else $error("trigger and sample on the same tick");

  a_raw_needs_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && raw_r) |-> (width_r != '0))
    else $error("present with zero width");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && out_v_r && !out_ready))
    else $error("input stalled without a full pipeline");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_v_r)
    else $error("processed item lost before the result register");
`endif

endmodule

### rtl/upr_seq.sv
`timescale 1ns / 1ps

module upr_seq #(
  parameter int GAP_TIMER_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic               echo,
  input  upr_pkg::cfg_t      cfg,
  output upr_pkg::seq_res_t  res
);

  localparam int CW = (GAP_TIMER_BITS > upr_pkg::GAP_W) ? GAP_TIMER_BITS : upr_pkg::GAP_W;
  localparam logic [GAP_TIMER_BITS-1:0] TMAX = {GAP_TIMER_BITS{1'b1}};

  upr_pkg::phase_t phase_r, phase_nxt;
  logic [GAP_TIMER_BITS-1:0]    timer_r, timer_nxt;
  logic [upr_pkg::WIDTH_W-1:0]  wait_r, wait_nxt;
  logic [upr_pkg::WIDTH_W-1:0]  wcnt_r, wcnt_nxt;

  logic [CW-1:0]                gap_ext;
  logic [GAP_TIMER_BITS-1:0]    gap_sat;
  logic [GAP_TIMER_BITS-1:0]    timer_inc;
  logic [GAP_TIMER_BITS-1:0]    timer_hold;
  logic [upr_pkg::WIDTH_W:0]    n;

  always_comb begin
    gap_ext    = CW'(cfg.gap_ticks);
    gap_sat    = (gap_ext > CW'(TMAX)) ? TMAX : gap_ext[GAP_TIMER_BITS-1:0];
    timer_inc  = timer_r + 1'b1;
    timer_hold = (timer_r == TMAX) ? timer_r : timer_inc;
    n          = {1'b0, wait_r} + 1'b1;
  end

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    wait_nxt  = wait_r;
    wcnt_nxt  = wcnt_r;
    res       = '0;
    case (phase_r)
      upr_pkg::PH_TRIGGER: begin
        res.trig = 1'b1;
        if (timer_inc >= GAP_TIMER_BITS'(cfg.trigger_ticks)) begin
          phase_nxt = upr_pkg::PH_WAIT;
          timer_nxt = '0;
          wait_nxt  = '0;
          wcnt_nxt  = '0;
        end else begin
          timer_nxt = timer_inc;
        end
      end
      upr_pkg::PH_GAP: begin
        if (timer_hold >= gap_sat) begin
          phase_nxt = upr_pkg::PH_TRIGGER;
          timer_nxt = '0;
        end else begin
          timer_nxt = timer_hold;
        end
      end
      upr_pkg::PH_WAIT, upr_pkg::PH_HIGH: begin
        wait_nxt = n[upr_pkg::WIDTH_W-1:0];
        if (phase_r == upr_pkg::PH_HIGH && !echo) begin
          res.done  = 1'b1;
          res.width = wcnt_r;
        end else if (n > {1'b0, cfg.timeout_ticks}) begin
          res.done = 1'b1;
        end else if (phase_r == upr_pkg::PH_WAIT) begin
          if (echo) begin
            phase_nxt = upr_pkg::PH_HIGH;
            wcnt_nxt  = upr_pkg::WIDTH_W'(1);
          end
        end else begin
          wcnt_nxt = wcnt_r + 1'b1;
        end
        // measurement over: drop counters, head for the gap
        if (res.done) begin
          wait_nxt  = '0;
          wcnt_nxt  = '0;
          timer_nxt = '0;
          phase_nxt = (cfg.gap_ticks == '0) ? upr_pkg::PH_TRIGGER : upr_pkg::PH_GAP;
        end
      end
      default: begin
        phase_nxt = upr_pkg::PH_TRIGGER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= upr_pkg::PH_TRIGGER;
      timer_r <= '0;
      wait_r  <= '0;
      wcnt_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      wait_r  <= wait_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

endmodule

### rtl/upr_dbnc.sv
`timescale 1ns / 1ps

module upr_dbnc (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  upr_pkg::seq_res_t            seq,
  input  upr_pkg::cfg_t                cfg,
  output upr_pkg::dbnc_res_t           res
);

  logic                         level_r, level_nxt;
  logic [upr_pkg::DBNC_W-1:0]   streak_r, streak_nxt;
  logic [upr_pkg::DIST_W-1:0]   dist_mcm;
  logic                         raw;
  logic [upr_pkg::DBNC_W-1:0]   streak_upd;

  always_comb begin
    // width * 17 as a shift and add
    dist_mcm = ({5'b0, seq.width} << 4) + {5'b0, seq.width};
    raw  = seq.done && (seq.width != '0) && (dist_mcm <= cfg.presence_limit);

    level_nxt  = level_r;
    streak_nxt = streak_r;
    streak_upd = streak_r;
    if (seq.done) begin
      if (raw != level_r) begin
        streak_upd = (streak_r == '1) ? streak_r : streak_r + 1'b1;
      end else begin
        streak_upd = '0;
      end
      streak_nxt = streak_upd;
      if (streak_upd >= cfg.debounce_len) begin
        level_nxt  = raw;
        streak_nxt = '0;
      end
    end

    res.dist_mcm = seq.done ? dist_mcm : '0;
    res.raw      = raw;
    res.presence = level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= 1'b0;
      streak_r <= '0;
    end else if (step_en) begin
      level_r  <= level_nxt;
      streak_r <= streak_nxt;
    end
  end

endmodule

### test/tb_ultrasonic_presence_ranger_unit.sv
`timescale 1ns / 1ps

module tb_ultrasonic_presence_ranger_unit;

  localparam int GAP_TIMER_BITS = 24;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned TOTAL_ITEMS = 2000;

  typedef logic [upr_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct packed {
    logic                        trig;
    logic                        valid;
    logic [upr_pkg::WIDTH_W-1:0] width;
    logic [upr_pkg::DIST_W-1:0]  dist_mcm;
    logic                        raw;
    logic                        pres;
  } tick_result_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic                             in_echo_level;
  logic                             out_valid;
  logic                             out_ready;
  logic                             out_trigger_level;
  logic                             out_sample_valid;
  logic [upr_pkg::WIDTH_W-1:0]      out_echo_width;
  logic [upr_pkg::DIST_W-1:0]       out_distance_mcm;
  logic                             out_raw_present;
  logic                             out_presence;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [upr_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [upr_pkg::CFG_DATA_W-1:0]   cfg_data;

  // mirror of the ranger's state and registers
  upr_pkg::cfg_t                 cfg_now;
  upr_pkg::phase_t               ph = upr_pkg::PH_TRIGGER;
  logic [GAP_TIMER_BITS-1:0]     ph_timer = '0;
  logic [upr_pkg::WIDTH_W-1:0]   wait_n = '0;
  logic [upr_pkg::WIDTH_W-1:0]   width_cnt = '0;
  logic                          pres_level = 1'b0;
  logic [upr_pkg::DBNC_W-1:0]    streak = '0;

  tick_result_t expected_ticks[$];
  int unsigned  mismatch_count = 0;
  int unsigned  sent_items = 0;
  int unsigned  cycle_count = 0;
  bit           idle_en = 1'b1;
  bit           hold_req = 1'b0;

  ultrasonic_presence_ranger_unit #(
    .GAP_TIMER_BITS(GAP_TIMER_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_echo_level    (in_echo_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_trigger_level(out_trigger_level),
    .out_sample_valid (out_sample_valid),
    .out_echo_width   (out_echo_width),
    .out_distance_mcm (out_distance_mcm),
    .out_raw_present  (out_raw_present),
    .out_presence     (out_presence),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void predict_tick(input logic echo);
    tick_result_t                r;
    logic [upr_pkg::WIDTH_W:0]   elapsed;
    logic                        done;
    r = '0;
    done = 1'b0;
    if (ph == upr_pkg::PH_TRIGGER) begin
      r.trig = 1'b1;
      ph_timer = ph_timer + 1'b1;
      if (ph_timer >= cfg_now.trigger_ticks) begin
        ph = upr_pkg::PH_WAIT;
        ph_timer = '0;
        wait_n = '0;
        width_cnt = '0;
      end
    end else if (ph == upr_pkg::PH_GAP) begin
      if (ph_timer != '1) ph_timer = ph_timer + 1'b1;
      if (ph_timer >= cfg_now.gap_ticks) begin
        ph = upr_pkg::PH_TRIGGER;
        ph_timer = '0;
      end
    end else begin
      elapsed = wait_n + 1'b1;
      if (ph == upr_pkg::PH_HIGH && !echo) begin
        r.width = width_cnt;
        done = 1'b1;
      end else if (elapsed > cfg_now.timeout_ticks) begin
        r.width = '0;
        done = 1'b1;
      end else if (ph == upr_pkg::PH_WAIT) begin
        if (echo) begin
          ph = upr_pkg::PH_HIGH;
          width_cnt = upr_pkg::WIDTH_W'(1);
        end
      end else begin
        width_cnt = width_cnt + 1'b1;
      end
      wait_n = elapsed[upr_pkg::WIDTH_W-1:0];
    end
    if (done) begin
      r.valid = 1'b1;
      r.dist_mcm = upr_pkg::DIST_W'(r.width * upr_pkg::DIST_FACTOR);
      r.raw = (r.width != 0) && (r.dist_mcm <= cfg_now.presence_limit);
      if (r.raw != pres_level) begin
        if (streak != '1) streak = streak + 1'b1;
      end else begin
        streak = '0;
      end
      if (streak >= cfg_now.debounce_len) begin
        pres_level = r.raw;
        streak = '0;
      end
      wait_n = '0;
      width_cnt = '0;
      ph_timer = '0;
      if (cfg_now.gap_ticks == 0) ph = upr_pkg::PH_TRIGGER;
      else ph = upr_pkg::PH_GAP;
    end
    r.pres = pres_level;
    expected_ticks.push_back(r);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    tick_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        $error("result item with nothing expected");
        mismatch_count++;
      end else begin
        want = expected_ticks.pop_front();
        check_field("trigger_level", 32'(want.trig), 32'(out_trigger_level));
        check_field("sample_valid", 32'(want.valid), 32'(out_sample_valid));
        check_field("echo_width", 32'(want.width), 32'(out_echo_width));
        check_field("distance_mcm", 32'(want.dist_mcm), 32'(out_distance_mcm));
        check_field("raw_present", 32'(want.raw), 32'(out_raw_present));
        check_field("presence", 32'(want.pres), 32'(out_presence));
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ultrasonic_presence_ranger_unit verification failed");
    $finish;
  end

  task automatic send_tick(input logic echo);
    int unsigned pause;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      pause = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_echo_level <= echo;
    do @(posedge clk); while (!in_ready);
    predict_tick(echo);
    sent_items++;
  endtask

  task automatic write_reg(input logic [upr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [upr_pkg::CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    // drain everything in flight before touching a register
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      upr_pkg::CFG_TRIGGER_TICKS:  cfg_now.trigger_ticks  = data[upr_pkg::TRIG_W-1:0];
      upr_pkg::CFG_TIMEOUT_TICKS:  cfg_now.timeout_ticks  = data[upr_pkg::WIDTH_W-1:0];
      upr_pkg::CFG_GAP_TICKS:      cfg_now.gap_ticks      = data[upr_pkg::GAP_W-1:0];
      upr_pkg::CFG_PRESENCE_LIMIT: cfg_now.presence_limit = data[upr_pkg::DIST_W-1:0];
      upr_pkg::CFG_DEBOUNCE_LEN:   cfg_now.debounce_len   = data[upr_pkg::DBNC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int unsigned trig_len, input int unsigned tmo,
                           input int unsigned gap, input int unsigned limit,
                           input int unsigned dbnc);
    write_reg(upr_pkg::CFG_TRIGGER_TICKS, cfg_word_t'(trig_len));
    write_reg(upr_pkg::CFG_TIMEOUT_TICKS, cfg_word_t'(tmo));
    write_reg(upr_pkg::CFG_GAP_TICKS, cfg_word_t'(gap));
    write_reg(upr_pkg::CFG_PRESENCE_LIMIT, cfg_word_t'(limit));
    write_reg(upr_pkg::CFG_DEBOUNCE_LEN, cfg_word_t'(dbnc));
  endtask

  // one trigger/echo cycle: echo rises after d wait ticks and stays high w ticks
  task automatic run_measurement(input int unsigned d, input int unsigned w,
                                 input int unsigned noise);
    int unsigned k;
    logic        e;
    while (ph == upr_pkg::PH_TRIGGER || ph == upr_pkg::PH_GAP) begin
      send_tick(1'($urandom_range(0, 1)));
    end
    k = 0;
    do begin
      e = (k >= d) && (k < d + w);
      if (noise != 0 && $urandom_range(0, 99) < noise) e = ~e;
      send_tick(e);
      k++;
    end while (ph == upr_pkg::PH_WAIT || ph == upr_pkg::PH_HIGH);
  endtask

  task automatic test_reset_defaults();
    // echo during the trigger pulse must be ignored
    repeat (10) send_tick(1'b1);
    repeat (4) send_tick(1'b0);
  endtask

  task automatic test_zero_lengths();
    write_reg(upr_pkg::CFG_TRIGGER_TICKS, '0);
    write_reg(upr_pkg::CFG_TIMEOUT_TICKS, '0);
    write_reg(upr_pkg::CFG_GAP_TICKS, '0);
    // upper bits dropped: reads back as zero length
    write_reg(upr_pkg::CFG_DEBOUNCE_LEN, 24'h000010);
    repeat (6) send_tick(1'($urandom_range(0, 1)));
  endtask

  task automatic test_presence_window();
    write_all(1, 6, 0, 'hFFFFFF, 1);
    run_measurement(0, 2, 0);
    run_measurement(1, 9, 0);
    write_reg(upr_pkg::CFG_PRESENCE_LIMIT, '0);
    run_measurement(2, 1, 0);
    write_reg(upr_pkg::CFG_PRESENCE_LIMIT, cfg_word_t'(upr_pkg::DIST_FACTOR));
    run_measurement(0, 1, 0);
    run_measurement(0, 2, 0);
  endtask

  task automatic test_long_gap();
    write_all(3, 131071, 'hFFFFFF, 2228207, 15);
    run_measurement(3, 4, 0);
    repeat (12) send_tick(1'($urandom_range(0, 1)));
    // shorten the gap while the timer is running
    write_reg(upr_pkg::CFG_GAP_TICKS, '0);
    run_measurement(0, 5, 0);
  endtask

  task automatic test_backpressure();
    write_all(2, 20, 3, 170, 2);
    hold_req = 1'b1;
    repeat (6) run_measurement($urandom_range(0, 3), $urandom_range(1, 22), 0);
  endtask

  task automatic random_phase();
    int unsigned kind, trig_len, tmo, gap, limit, dbnc, count, noise, w;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      trig_len = 1; tmo = 1; gap = 0; limit = 0; dbnc = 1; count = 10; noise = 10;
    end else if (kind == 1) begin
      trig_len = 255; tmo = 131071; gap = $urandom_range(0, 3); limit = 2228207;
      dbnc = 15; count = 3; noise = 0;
    end else if (kind <= 3) begin
      trig_len = $urandom_range(1, 40);
      tmo = $urandom_range(60, 400);
      gap = $urandom_range(0, 50);
      limit = $urandom_range(0, upr_pkg::DIST_FACTOR * 400);
      dbnc = $urandom_range(1, 6);
      count = $urandom_range(3, 6);
      noise = ($urandom_range(0, 1) == 0) ? 0 : 3;
    end else begin
      trig_len = $urandom_range(1, 12);
      tmo = $urandom_range(1, 40);
      gap = $urandom_range(0, 15);
      limit = $urandom_range(0, upr_pkg::DIST_FACTOR * (tmo + 3));
      dbnc = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
      count = $urandom_range(8, 25);
      noise = ($urandom_range(0, 3) == 0) ? 8 : 0;
    end
    write_all(trig_len, tmo, gap, limit, dbnc);
    repeat (count) begin
      if (tmo > 400) w = $urandom_range(1, 300);
      else if ($urandom_range(0, 3) == 0) w = $urandom_range(1, 3);
      else w = $urandom_range(1, tmo + 3);
      run_measurement($urandom_range(0, 8), w, noise);
    end
  endtask

  task automatic test_random_ranging();
    while (sent_items < RANDOM_ITEMS) random_phase();
  endtask

  task automatic test_full_rate();
    idle_en = 1'b0;
    while (sent_items < TOTAL_ITEMS) random_phase();
  endtask

  initial begin
    cfg_now.trigger_ticks  = upr_pkg::RST_TRIGGER_TICKS;
    cfg_now.timeout_ticks  = upr_pkg::RST_TIMEOUT_TICKS;
    cfg_now.gap_ticks      = upr_pkg::RST_GAP_TICKS;
    cfg_now.presence_limit = upr_pkg::RST_PRESENCE_LIMIT;
    cfg_now.debounce_len   = upr_pkg::RST_DEBOUNCE_LEN;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_echo_level <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zero_lengths();
    test_presence_window();
    test_long_gap();
    test_backpressure();
    test_random_ranging();
    test_full_rate();

    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ultrasonic_presence_ranger_unit verification clean");
    end else begin
      $display("ultrasonic_presence_ranger_unit verification failed");
    end
    $finish;
  end

endmodule
